@@ hw/rtl/ep2h_pkg.sv @@
package ep2h_pkg;

  // Number of CORDIC iterations requested, and the number actually built.
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int N_STAGES = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // Datapath widths: angles in Q.30 need 34 bits before reduction.
  localparam int AW = 34;
  localparam int SW = $clog2(ATAN_ENTRIES);

  // Latency from request to result: reduce, cells, sign fix, three product stages.
  localparam int LATENCY = N_STAGES + 5;

  localparam logic signed [AW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [AW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0]   ONE_Q14     = 16'sd16384;

  // atan(2^-i) in Q.30, truncated.
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // State one CORDIC cell hands to the next.
  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
    logic                 neg;
  } cordic_t;

  // Sine and cosine of one angle in Q.30.
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sincos_t;

  // Clamp a rounded value to [-1, 1] in Q1.14.
  function automatic logic signed [15:0] sat_q14(input logic signed [65:0] v);
    logic signed [15:0] r;
    if (v > 66'sd16384) begin
      r = ONE_Q14;
    end else if (v < -66'sd16384) begin
      r = -ONE_Q14;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Round a Q.60 value (one product or the sum of two) to Q.14 and clamp.
  function automatic logic signed [15:0] round_q60(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< 45)) >>> 46;
    return sat_q14(t);
  endfunction

endpackage

@@ hw/rtl/ep2h_cordic_cell.sv @@
module ep2h_cordic_cell import ep2h_pkg::*; (
  input  logic          clk_i,
  input  logic [SW-1:0] stage_i,
  input  cordic_t       in_i,
  output cordic_t       out_o
);

  cordic_t            cell_d, cell_q;
  logic signed [AW-1:0] dx, dy, at;

  // One micro-rotation; the direction follows the sign of the residual angle.
  always_comb begin
    dx = in_i.y >>> stage_i;
    dy = in_i.x >>> stage_i;
    at = AW'(signed'({1'b0, ATAN_TAB[stage_i]}));
    cell_d.neg = in_i.neg;
    if (!in_i.z[AW-1]) begin
      cell_d.x = in_i.x - dx;
      cell_d.y = in_i.y + dy;
      cell_d.z = in_i.z - at;
    end else begin
      cell_d.x = in_i.x + dx;
      cell_d.y = in_i.y - dy;
      cell_d.z = in_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign out_o = cell_q;

endmodule

@@ hw/rtl/ep2h_matrix.sv @@
module ep2h_matrix import ep2h_pkg::*; (
  input  logic               clk_i,
  input  sincos_t            rx_i,
  input  sincos_t            ry_i,
  input  sincos_t            rz_i,
  output logic signed [15:0] r00_o,
  output logic signed [15:0] r01_o,
  output logic signed [15:0] r02_o,
  output logic signed [15:0] r10_o,
  output logic signed [15:0] r11_o,
  output logic signed [15:0] r12_o,
  output logic signed [15:0] r20_o,
  output logic signed [15:0] r21_o,
  output logic signed [15:0] r22_o
);

  sincos_t            rx_q, ry_q, rz_q;
  logic signed [31:0] czsy_q, szsy_q;
  logic signed [63:0] czsy_full, szsy_full;
  logic signed [63:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q, pg_q, ph_q;
  logic signed [63:0] p00_q, p10_q, p21_q, p22_q;
  logic signed [15:0] r20_q;
  logic signed [AW-1:0] r20_t;

  // First stage: the shared pitch terms, floored back to Q.30.
  assign czsy_full = rz_i.c * ry_i.s;
  assign szsy_full = rz_i.s * ry_i.s;

  always_ff @(posedge clk_i) begin
    rx_q   <= rx_i;
    ry_q   <= ry_i;
    rz_q   <= rz_i;
    czsy_q <= 32'(czsy_full >>> 30);
    szsy_q <= 32'(szsy_full >>> 30);
  end

  // Second stage: every Q.60 product, and the bottom-left entry straight from sin pitch.
  always_comb begin
    r20_t = ((-AW'(ry_q.s)) + AW'(32768)) >>> 16;
  end

  always_ff @(posedge clk_i) begin
    pa_q  <= czsy_q * rx_q.s;
    pb_q  <= rz_q.s * rx_q.c;
    pc_q  <= czsy_q * rx_q.c;
    pd_q  <= rz_q.s * rx_q.s;
    pe_q  <= szsy_q * rx_q.s;
    pf_q  <= rz_q.c * rx_q.c;
    pg_q  <= szsy_q * rx_q.c;
    ph_q  <= rz_q.c * rx_q.s;
    p00_q <= rz_q.c * ry_q.c;
    p10_q <= rz_q.s * ry_q.c;
    p21_q <= ry_q.c * rx_q.s;
    p22_q <= ry_q.c * rx_q.c;
    r20_q <= sat_q14(66'(r20_t));
  end

  // Third stage: sums, rounding and clamping into the output registers.
  always_ff @(posedge clk_i) begin
    r00_o <= round_q60(66'(p00_q));
    r01_o <= round_q60(66'(pa_q) - 66'(pb_q));
    r02_o <= round_q60(66'(pc_q) + 66'(pd_q));
    r10_o <= round_q60(66'(p10_q));
    r11_o <= round_q60(66'(pe_q) + 66'(pf_q));
    r12_o <= round_q60(66'(pg_q) - 66'(ph_q));
    r20_o <= r20_q;
    r21_o <= round_q60(66'(p21_q));
    r22_o <= round_q60(66'(p22_q));
  end

endmodule

@@ hw/rtl/euler_pose_to_homogeneous_matrix_unit.sv @@
// Channel   Handshake          Payload
// request   start_i / busy_o   pos_x_i pos_y_i pos_z_i roll_i pitch_i yaw_i
// result    valid_o            r00_o .. r22_o, trans_x_o trans_y_o trans_z_o
//
// A request is taken in every cycle; busy_o stays low.
// Each result passes through angle reduction, the CORDIC cells, the sign fix and
// three product stages.
// Reset clears only the valid pipeline; results are strobed for one cycle and
// the receiver cannot stall them.
module euler_pose_to_homogeneous_matrix_unit import ep2h_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] roll_i,
  input  logic signed [15:0] pitch_i,
  input  logic signed [15:0] yaw_i,
  output logic               valid_o,
  output logic signed [15:0] r00_o,
  output logic signed [15:0] r01_o,
  output logic signed [15:0] r02_o,
  output logic signed [15:0] r10_o,
  output logic signed [15:0] r11_o,
  output logic signed [15:0] r12_o,
  output logic signed [15:0] r20_o,
  output logic signed [15:0] r21_o,
  output logic signed [15:0] r22_o,
  output logic signed [31:0] trans_x_o,
  output logic signed [31:0] trans_y_o,
  output logic signed [31:0] trans_z_o
);

  logic [LATENCY-1:0]  vld_q;
  logic signed [31:0]  tx_q [LATENCY];
  logic signed [31:0]  ty_q [LATENCY];
  logic signed [31:0]  tz_q [LATENCY];
  logic signed [15:0]  ang [3];
  cordic_t             chain [3][N_STAGES+1];
  sincos_t             sc_q [3];

  assign busy_o = 1'b0;
  assign ang[0] = roll_i;
  assign ang[1] = pitch_i;
  assign ang[2] = yaw_i;

  // Request valid bits travel alongside the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start_i};
    end
  end

  // The translation is delayed to line up with the matrix.
  always_ff @(posedge clk_i) begin
    tx_q[0] <= pos_x_i;
    ty_q[0] <= pos_y_i;
    tz_q[0] <= pos_z_i;
    for (int k = 1; k < LATENCY; k++) begin
      tx_q[k] <= tx_q[k-1];
      ty_q[k] <= ty_q[k-1];
      tz_q[k] <= tz_q[k-1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    cordic_t red_d, red_q;

    // Fold the angle into [-pi/2, pi/2]; sine and cosine are negated later.
    always_comb begin
      red_d.x   = CORDIC_GAIN;
      red_d.y   = '0;
      red_d.z   = AW'(ang[l]) <<< 17;
      red_d.neg = 1'b0;
      if (red_d.z > ANG_HALF_PI) begin
        red_d.z   = red_d.z - ANG_PI;
        red_d.neg = 1'b1;
      end else if (red_d.z < -ANG_HALF_PI) begin
        red_d.z   = red_d.z + ANG_PI;
        red_d.neg = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      red_q <= red_d;
    end

    assign chain[l][0] = red_q;

    for (genvar s = 0; s < N_STAGES; s++) begin : g_cell
      ep2h_cordic_cell u_cell (
        .clk_i   (clk_i),
        .stage_i (SW'(s)),
        .in_i    (chain[l][s]),
        .out_o   (chain[l][s+1])
      );
    end

    // Undo the reduction by flipping the signs.
    always_ff @(posedge clk_i) begin
      if (chain[l][N_STAGES].neg) begin
        sc_q[l].c <= 32'(-chain[l][N_STAGES].x);
        sc_q[l].s <= 32'(-chain[l][N_STAGES].y);
      end else begin
        sc_q[l].c <= 32'(chain[l][N_STAGES].x);
        sc_q[l].s <= 32'(chain[l][N_STAGES].y);
      end
    end
  end

  ep2h_matrix u_matrix (
    .clk_i (clk_i),
    .rx_i  (sc_q[0]),
    .ry_i  (sc_q[1]),
    .rz_i  (sc_q[2]),
    .r00_o (r00_o),
    .r01_o (r01_o),
    .r02_o (r02_o),
    .r10_o (r10_o),
    .r11_o (r11_o),
    .r12_o (r12_o),
    .r20_o (r20_o),
    .r21_o (r21_o),
    .r22_o (r22_o)
  );

  assign valid_o   = vld_q[LATENCY-1];
  assign trans_x_o = tx_q[LATENCY-1];
  assign trans_y_o = ty_q[LATENCY-1];
  assign trans_z_o = tz_q[LATENCY-1];

  // Every request produces exactly one result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY valid_o)
    else $error("result missing after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LATENCY))
    else $error("result without request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (r00_o <= ONE_Q14 && r00_o >= -ONE_Q14 &&
                 r20_o <= ONE_Q14 && r20_o >= -ONE_Q14))
    else $error("matrix entry out of range");

endmodule
